>>> rtl/tfn_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tfn_pkg
// Shared types and widths for the triangle face normal pipeline.
// ---------------------------------------------------------------------------
package tfn_pkg;

  localparam int unsigned COORD_WIDTH = 24;
  localparam int unsigned EDGE_W      = COORD_WIDTH + 1;
  localparam int unsigned PROD_W      = 2 * EDGE_W;
  localparam int unsigned CROSS_W     = PROD_W + 1;
  localparam int unsigned MAG_W       = 2 * COORD_WIDTH + 1;
  localparam int unsigned HALF_W      = (MAG_W + 1) / 2;
  localparam int unsigned HI_W        = MAG_W - HALF_W;
  localparam int unsigned SQ_W        = 2 * MAG_W;
  localparam int unsigned LEN2_W      = SQ_W + 2;
  localparam int unsigned FRAC_BITS   = 14;
  localparam int unsigned K_W         = FRAC_BITS + 1;
  localparam int unsigned ACC_W       = LEN2_W + 2 * FRAC_BITS + 3;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned LANES       = 3;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] az;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by_coord;
    logic signed [COORD_WIDTH-1:0] bz;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
  } in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] nx;
    logic signed [OUT_W-1:0] ny;
    logic signed [OUT_W-1:0] nz;
    logic                    degenerate;
  } out_t;

endpackage
`default_nettype wire

>>> rtl/tfn_root_step.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tfn_root_step
// One restoring step of the quotient search: decides one bit of K such that
// K*K*len2 stays at or below the scaled square of the cross component.
// ---------------------------------------------------------------------------
module tfn_root_step #(
  parameter int unsigned BIT = 0
) (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [tfn_pkg::ACC_W-1:0]       rem_i,
  input  wire logic [tfn_pkg::ACC_W-1:0]       mul_i,
  input  wire logic [tfn_pkg::LEN2_W-1:0]      len2_i,
  input  wire logic [tfn_pkg::K_W-1:0]         k_i,
  output logic      [tfn_pkg::ACC_W-1:0]       rem_o,
  output logic      [tfn_pkg::ACC_W-1:0]       mul_o,
  output logic      [tfn_pkg::K_W-1:0]         k_o
);

  logic [tfn_pkg::ACC_W-1:0] len2_ext;
  logic [tfn_pkg::ACC_W-1:0] trial;
  logic                      take;
  logic [tfn_pkg::ACC_W-1:0] rem_nxt, rem_r;
  logic [tfn_pkg::ACC_W-1:0] mul_nxt, mul_r;
  logic [tfn_pkg::K_W-1:0]   k_nxt, k_r;

  // rem holds target - k*k*len2 and mul holds k*len2, so adding the bit
  // costs (2*k*bit + bit*bit)*len2, which is two shifted terms.
  always_comb begin
    len2_ext = tfn_pkg::ACC_W'(len2_i);
    trial    = (mul_i << (BIT + 1)) + (len2_ext << (2 * BIT));
    take     = (rem_i >= trial);
    rem_nxt  = take ? (rem_i - trial) : rem_i;
    mul_nxt  = take ? (mul_i + (len2_ext << BIT)) : mul_i;
    k_nxt    = take ? (k_i | (tfn_pkg::K_W'(1) << BIT)) : k_i;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      mul_r <= mul_nxt;
      k_r   <= k_nxt;
    end
  end

  assign rem_o = rem_r;
  assign mul_o = mul_r;
  assign k_o   = k_r;

endmodule
`default_nettype wire

>>> rtl/triangle_face_normal.sv
`default_nettype none
// ---------------------------------------------------------------------------
// triangle_face_normal
// Unit face normal of a triangle in Q1.14, exact truncation toward zero.
// ---------------------------------------------------------------------------
// The block accepts one triangle per clock and returns one normal per clock
// while out_stall is not holding a valid result. Registered front-end stages
// form the edges, the exact cross product and its squared length (the wide
// squares are split into half-width partial products), a chain of bit steps
// resolves one bit of each normal component apiece in three parallel lanes,
// and the output register holds the result. The whole pipeline holds while a
// valid result is stalled, so in_stall is out_stall gated by out_valid.
module triangle_face_normal (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire tfn_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output tfn_pkg::out_t       out_data
);

  localparam int unsigned NSTEP = tfn_pkg::K_W;

  logic en;

  logic                                v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic signed [tfn_pkg::EDGE_W-1:0]   e1x_r, e1y_r, e1z_r, e2x_r, e2y_r, e2z_r;
  logic signed [tfn_pkg::PROD_W-1:0]   p_r [tfn_pkg::LANES];
  logic signed [tfn_pkg::PROD_W-1:0]   q_r [tfn_pkg::LANES];
  logic [tfn_pkg::MAG_W-1:0]           mag_r [tfn_pkg::LANES];
  logic                                neg3_r [tfn_pkg::LANES];
  logic [2*tfn_pkg::HI_W-1:0]          hh_r [tfn_pkg::LANES];
  logic [tfn_pkg::HI_W+tfn_pkg::HALF_W-1:0] hl_r [tfn_pkg::LANES];
  logic [2*tfn_pkg::HALF_W-1:0]        ll_r [tfn_pkg::LANES];
  logic                                neg4_r [tfn_pkg::LANES];
  logic [tfn_pkg::SQ_W-1:0]            sq_r [tfn_pkg::LANES];
  logic                                neg5_r [tfn_pkg::LANES];
  logic [tfn_pkg::LEN2_W-1:0]          len2_6_r;
  logic [tfn_pkg::ACC_W-1:0]           tgt_r [tfn_pkg::LANES];
  logic                                neg6_r [tfn_pkg::LANES];

  logic [tfn_pkg::LEN2_W-1:0]          len2_s_r [NSTEP];
  logic                                neg_s_r [NSTEP][tfn_pkg::LANES];
  logic                                vs_r [NSTEP];

  logic [tfn_pkg::ACC_W-1:0]           rem_w [tfn_pkg::LANES][NSTEP+1];
  logic [tfn_pkg::ACC_W-1:0]           mul_w [tfn_pkg::LANES][NSTEP+1];
  logic [tfn_pkg::K_W-1:0]             k_w   [tfn_pkg::LANES][NSTEP+1];
  logic [tfn_pkg::LEN2_W-1:0]          len2_w [NSTEP+1];

  logic                                out_valid_r;
  tfn_pkg::out_t                       out_data_r, out_data_nxt;
  logic signed [tfn_pkg::OUT_W-1:0]    comp [tfn_pkg::LANES];
  logic                                degen;

  assign en        = !out_valid_r || !out_stall;
  assign in_stall  = !en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int j = 0; j < NSTEP; j++) vs_r[j] <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      vs_r[0] <= v6_r;
      for (int j = 1; j < NSTEP; j++) vs_r[j] <= vs_r[j-1];
      out_valid_r <= vs_r[NSTEP-1];
    end
  end

  // Front end: edges, products, cross product, squares, squared length.
  always_ff @(posedge clk) begin
    if (en) begin
      e1x_r <= {in_data.bx[tfn_pkg::COORD_WIDTH-1], in_data.bx}
             - {in_data.ax[tfn_pkg::COORD_WIDTH-1], in_data.ax};
      e1y_r <= {in_data.by_coord[tfn_pkg::COORD_WIDTH-1], in_data.by_coord}
             - {in_data.ay[tfn_pkg::COORD_WIDTH-1], in_data.ay};
      e1z_r <= {in_data.bz[tfn_pkg::COORD_WIDTH-1], in_data.bz}
             - {in_data.az[tfn_pkg::COORD_WIDTH-1], in_data.az};
      e2x_r <= {in_data.cx[tfn_pkg::COORD_WIDTH-1], in_data.cx}
             - {in_data.ax[tfn_pkg::COORD_WIDTH-1], in_data.ax};
      e2y_r <= {in_data.cy[tfn_pkg::COORD_WIDTH-1], in_data.cy}
             - {in_data.ay[tfn_pkg::COORD_WIDTH-1], in_data.ay};
      e2z_r <= {in_data.cz[tfn_pkg::COORD_WIDTH-1], in_data.cz}
             - {in_data.az[tfn_pkg::COORD_WIDTH-1], in_data.az};

      p_r[0] <= e1y_r * e2z_r;
      q_r[0] <= e1z_r * e2y_r;
      p_r[1] <= e1z_r * e2x_r;
      q_r[1] <= e1x_r * e2z_r;
      p_r[2] <= e1x_r * e2y_r;
      q_r[2] <= e1y_r * e2x_r;

      len2_6_r <= tfn_pkg::LEN2_W'(sq_r[0]) + tfn_pkg::LEN2_W'(sq_r[1])
                + tfn_pkg::LEN2_W'(sq_r[2]);
    end
  end

  for (genvar l = 0; l < tfn_pkg::LANES; l++) begin : g_front
    logic signed [tfn_pkg::CROSS_W-1:0] cprod;
    logic        [tfn_pkg::MAG_W-1:0]   cabs;
    logic        [tfn_pkg::HALF_W-1:0]  lo;
    logic        [tfn_pkg::HI_W-1:0]    hi;

    always_comb begin
      cprod = {p_r[l][tfn_pkg::PROD_W-1], p_r[l]} - {q_r[l][tfn_pkg::PROD_W-1], q_r[l]};
      cabs  = tfn_pkg::MAG_W'(cprod[tfn_pkg::CROSS_W-1] ? (tfn_pkg::CROSS_W'(0) - cprod)
                                                        : cprod);
      lo    = mag_r[l][tfn_pkg::HALF_W-1:0];
      hi    = mag_r[l][tfn_pkg::MAG_W-1:tfn_pkg::HALF_W];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[l]  <= cabs;
        neg3_r[l] <= cprod[tfn_pkg::CROSS_W-1];
        hh_r[l]   <= (2*tfn_pkg::HI_W)'(hi) * (2*tfn_pkg::HI_W)'(hi);
        hl_r[l]   <= (tfn_pkg::HI_W+tfn_pkg::HALF_W)'(hi)
                   * (tfn_pkg::HI_W+tfn_pkg::HALF_W)'(lo);
        ll_r[l]   <= (2*tfn_pkg::HALF_W)'(lo) * (2*tfn_pkg::HALF_W)'(lo);
        neg4_r[l] <= neg3_r[l];
        sq_r[l]   <= (tfn_pkg::SQ_W'(hh_r[l]) << (2*tfn_pkg::HALF_W))
                   + (tfn_pkg::SQ_W'(hl_r[l]) << (tfn_pkg::HALF_W + 1))
                   + tfn_pkg::SQ_W'(ll_r[l]);
        neg5_r[l] <= neg4_r[l];
        tgt_r[l]  <= tfn_pkg::ACC_W'(sq_r[l]) << (2*tfn_pkg::FRAC_BITS);
        neg6_r[l] <= neg5_r[l];
      end
    end

    assign rem_w[l][0] = tgt_r[l];
    assign mul_w[l][0] = '0;
    assign k_w[l][0]   = '0;
  end

  // Side information that travels with the bit steps.
  always_ff @(posedge clk) begin
    if (en) begin
      len2_s_r[0] <= len2_6_r;
      for (int l = 0; l < tfn_pkg::LANES; l++) neg_s_r[0][l] <= neg6_r[l];
      for (int j = 1; j < NSTEP; j++) begin
        len2_s_r[j] <= len2_s_r[j-1];
        for (int l = 0; l < tfn_pkg::LANES; l++) neg_s_r[j][l] <= neg_s_r[j-1][l];
      end
    end
  end

  assign len2_w[0] = len2_6_r;
  for (genvar j = 0; j < NSTEP; j++) begin : g_len2
    assign len2_w[j+1] = len2_s_r[j];
  end

  for (genvar l = 0; l < tfn_pkg::LANES; l++) begin : g_lane
    for (genvar j = 0; j < NSTEP; j++) begin : g_step
      tfn_root_step #(
        .BIT (NSTEP - 1 - j)
      ) u_step (
        .clk    (clk),
        .en     (en),
        .rem_i  (rem_w[l][j]),
        .mul_i  (mul_w[l][j]),
        .len2_i (len2_w[j]),
        .k_i    (k_w[l][j]),
        .rem_o  (rem_w[l][j+1]),
        .mul_o  (mul_w[l][j+1]),
        .k_o    (k_w[l][j+1])
      );
    end
  end

  // A zero squared length means a degenerate triangle and a zero normal.
  always_comb begin
    degen = (len2_w[NSTEP] == '0);
    for (int l = 0; l < tfn_pkg::LANES; l++) begin
      if (degen) begin
        comp[l] = '0;
      end else if (neg_s_r[NSTEP-1][l]) begin
        comp[l] = tfn_pkg::OUT_W'(0) - tfn_pkg::OUT_W'(k_w[l][NSTEP]);
      end else begin
        comp[l] = tfn_pkg::OUT_W'(k_w[l][NSTEP]);
      end
    end
    out_data_nxt.nx         = comp[0];
    out_data_nxt.ny         = comp[1];
    out_data_nxt.nz         = comp[2];
    out_data_nxt.degenerate = degen;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule
`default_nettype wire
